>>> rtl/lfs_pkg.sv
package lfs_pkg;

    localparam int DATA_W  = 16;
    localparam int RING_AW = 12;   // covers up to 16 frames of 256 values
    localparam int COEF_AW = 10;
    localparam logic [15:0] FRAME_COUNT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_MEAN  = 2'd0,
        CMD_SCALE = 2'd1,
        CMD_PUSH  = 2'd2,
        CMD_PULL  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_READY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_DIM    = 2'd0,
        CFG_FRAMES = 2'd1,
        CFG_STRIDE = 2'd2,
        CFG_CMVN   = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_RING_WR,
        OP_MEAN_WR,
        OP_SCALE_WR,
        OP_READ
    } t_op;

    // one classified request, front to back
    typedef struct packed {
        t_op                 op;
        t_status             status;
        logic [DATA_W-1:0]   data;
        logic [RING_AW-1:0]  ring_addr;
        logic [COEF_AW-1:0]  coef_addr;
        logic                cmvn;
        logic                last_w;
        logic                last_u;
    } t_req;

endpackage

>>> rtl/lfr_frame_stacker_cmvn.sv
// Low-frame-rate stacker with optional mean/scale normalization. Every request
// (mean load, scale load, feature push, output pull) yields one response with a
// status; a pull that succeeds carries one stacked Q8.8 value and window and
// utterance end flags. One request is taken per clock while the queue has room:
// the front classifies it and updates the window counters as it is taken, and a
// four-entry queue hands it to a three-stage back end (ring/table read, add and
// 17x16 multiply, round and saturate) that holds whenever the output is stalled.
// Ring and coefficient tables come up undefined and need no clearing; load
// coefficients before enabling normalization.
module lfr_frame_stacker_cmvn #(
    parameter int MAX_DIM     = 128,
    parameter int RING_FRAMES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_sample_value,
    input  logic [9:0]  i_coef_index,
    input  logic        i_end_of_utterance,
    // response channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_out_value,
    output logic        o_last_of_window,
    output logic        o_last_of_utterance
);

    lfs_pkg::t_req front_req;
    lfs_pkg::t_req queue_req;
    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;

    // front: config, counters, readiness, ring/coef addressing
    lfs_front #(
        .MAX_DIM     (MAX_DIM),
        .RING_FRAMES (RING_FRAMES)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_cmd              (i_cmd),
        .i_sample_value     (i_sample_value),
        .i_coef_index       (i_coef_index),
        .i_end_of_utterance (i_end_of_utterance),
        .i_q_full           (q_full),
        .o_q_push           (q_push),
        .o_req              (front_req)
    );

    lfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_req   (front_req),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_req   (queue_req),
        .o_empty (q_empty)
    );

    // back: memories and normalize pipeline, stalls only on the output side
    lfs_back #(
        .MAX_DIM     (MAX_DIM),
        .RING_FRAMES (RING_FRAMES)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_req               (queue_req),
        .i_q_empty           (q_empty),
        .o_q_pop             (q_pop),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_status            (o_status),
        .o_out_value         (o_out_value),
        .o_last_of_window    (o_last_of_window),
        .o_last_of_utterance (o_last_of_utterance)
    );

endmodule

>>> rtl/lfs_queue.sv
module lfs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lfs_pkg::t_req i_req,
    output logic          o_full,
    input  logic          i_pop,
    output lfs_pkg::t_req o_req,
    output logic          o_empty
);

    lfs_pkg::t_req r_mem [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 3'd4);
    assign o_empty = (r_count == 3'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_req   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 2'd1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 3'd1;
                2'b01:   r_count <= r_count - 3'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/lfs_front.sv
module lfs_front #(
    parameter int MAX_DIM     = 128,
    parameter int RING_FRAMES = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [7:0]    i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_cmd,
    input  logic [15:0]   i_sample_value,
    input  logic [9:0]    i_coef_index,
    input  logic          i_end_of_utterance,
    input  logic          i_q_full,
    output logic          o_q_push,
    output lfs_pkg::t_req o_req
);

    localparam int EW = $clog2(MAX_DIM);
    localparam int SW = $clog2(RING_FRAMES);

    logic [7:0]    r_dim;
    logic [2:0]    r_m;
    logic [2:0]    r_n;
    logic          r_cmvn;
    logic [EW-1:0] r_eif,   n_eif;
    logic [15:0]   r_frames, n_frames;
    logic [15:0]   r_wn,    n_wn;
    logic [2:0]    r_fiw,   n_fiw;
    logic [EW-1:0] r_eiw,   n_eiw;
    logic          r_ended, n_ended;
    logic [SW-1:0] r_wr_slot, n_wr_slot;

    logic          accept;
    logic [8:0]    d_eff;
    logic [2:0]    m_eff;
    logic [2:0]    n_eff;
    logic [1:0]    pad;
    logic [18:0]   wstart;
    logic [19:0]   s_pos;
    logic [19:0]   src;
    logic [19:0]   fr20;
    logic [19:0]   wend;
    logic          last_e;
    logic          last_w;
    logic          last_u;
    logic [19:0]   f_rd;
    logic [19:0]   diff;
    logic [5:0]    slot_t;
    logic [5:0]    slot;
    logic          pull_ok;
    logic          push_full;
    logic          frame_done;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_q_push   = accept;

    always_comb begin
        if (r_dim == 8'd0) begin
            d_eff = 9'd1;
        end else if ({1'b0, r_dim} > 9'(MAX_DIM)) begin
            d_eff = 9'(MAX_DIM);
        end else begin
            d_eff = {1'b0, r_dim};
        end
    end

    assign m_eff  = (r_m == 3'd0) ? 3'd1 : r_m;
    assign n_eff  = (r_n == 3'd0) ? 3'd1 : r_n;
    assign pad    = 2'((m_eff - 3'd1) >> 1);
    assign wstart = 19'(r_wn) * 19'(n_eff);
    assign s_pos  = {1'b0, wstart} + 20'(r_fiw);
    assign src    = (s_pos > 20'(pad)) ? s_pos - 20'(pad) : 20'd0;
    assign fr20   = 20'(r_frames);
    assign wend   = {1'b0, wstart} + 20'(n_eff);

    assign last_e = (9'(r_eiw) + 9'd1) >= d_eff;
    assign last_w = last_e && ((4'(r_fiw) + 4'd1) >= 4'(m_eff));
    assign last_u = last_w && r_ended && (wend >= fr20);

    assign f_rd   = (r_ended && src >= fr20) ? fr20 - 20'd1 : src;
    // source frame trails the write slot by 1..2*RING_FRAMES-1 frames
    // (a new window can step back over frames the ring already reused)
    assign diff   = fr20 - f_rd;
    assign slot_t = 6'(r_wr_slot) + 6'(2 * RING_FRAMES) - 6'(diff[5:0]);
    assign slot   = (slot_t >= 6'(2 * RING_FRAMES)) ? slot_t - 6'(2 * RING_FRAMES) :
                    (slot_t >= 6'(RING_FRAMES))     ? slot_t - 6'(RING_FRAMES) : slot_t;

    assign pull_ok = (r_frames != 16'd0) &&
                     (r_ended || ((src < fr20) && ({1'b0, wstart} < fr20) &&
                                  !(last_w && (wend >= fr20))));

    assign push_full = r_ended ||
                       ((fr20 >= src) && ((fr20 - src) >= 20'(RING_FRAMES))) ||
                       ((r_frames == lfs_pkg::FRAME_COUNT_MAX) && !i_end_of_utterance);

    assign frame_done = (9'(r_eif) + 9'd1) >= d_eff;

    always_comb begin
        n_eif     = r_eif;
        n_frames  = r_frames;
        n_wn      = r_wn;
        n_fiw     = r_fiw;
        n_eiw     = r_eiw;
        n_ended   = r_ended;
        n_wr_slot = r_wr_slot;

        o_req           = '0;
        o_req.op        = lfs_pkg::OP_NONE;
        o_req.status    = lfs_pkg::ST_DONE;
        o_req.data      = i_sample_value;
        o_req.coef_addr = i_coef_index;
        o_req.cmvn      = r_cmvn;

        case (lfs_pkg::t_cmd'(i_cmd))
            lfs_pkg::CMD_MEAN: begin
                o_req.op = lfs_pkg::OP_MEAN_WR;
            end
            lfs_pkg::CMD_SCALE: begin
                o_req.op = lfs_pkg::OP_SCALE_WR;
            end
            lfs_pkg::CMD_PUSH: begin
                if (push_full) begin
                    o_req.status = lfs_pkg::ST_FULL;
                end else begin
                    if (r_frames != lfs_pkg::FRAME_COUNT_MAX) begin
                        o_req.op        = lfs_pkg::OP_RING_WR;
                        o_req.ring_addr = lfs_pkg::RING_AW'(r_wr_slot) *
                                          lfs_pkg::RING_AW'(MAX_DIM) +
                                          lfs_pkg::RING_AW'(r_eif);
                        if (frame_done) begin
                            n_eif     = '0;
                            n_frames  = r_frames + 16'd1;
                            n_wr_slot = (r_wr_slot == SW'(RING_FRAMES - 1)) ?
                                        '0 : r_wr_slot + SW'(1);
                        end else begin
                            n_eif = r_eif + EW'(1);
                        end
                    end
                    if (i_end_of_utterance) begin
                        n_eif   = '0;
                        n_ended = 1'b1;
                        // empty utterance closes at once
                        if (n_frames == 16'd0) begin
                            n_wn      = '0;
                            n_fiw     = '0;
                            n_eiw     = '0;
                            n_ended   = 1'b0;
                            n_wr_slot = '0;
                        end
                    end
                end
            end
            default: begin
                if (!pull_ok) begin
                    o_req.status = lfs_pkg::ST_NOT_READY;
                end else begin
                    o_req.op        = lfs_pkg::OP_READ;
                    o_req.ring_addr = lfs_pkg::RING_AW'(slot) *
                                      lfs_pkg::RING_AW'(MAX_DIM) +
                                      lfs_pkg::RING_AW'(r_eiw);
                    o_req.coef_addr = lfs_pkg::COEF_AW'(11'(r_fiw) * 11'(d_eff) +
                                                        11'(r_eiw));
                    o_req.last_w    = last_w;
                    o_req.last_u    = last_u;
                    if (last_u) begin
                        n_eif     = '0;
                        n_frames  = '0;
                        n_wn      = '0;
                        n_fiw     = '0;
                        n_eiw     = '0;
                        n_ended   = 1'b0;
                        n_wr_slot = '0;
                    end else if (last_e) begin
                        n_eiw = '0;
                        if (last_w) begin
                            n_fiw = '0;
                            n_wn  = r_wn + 16'd1;
                        end else begin
                            n_fiw = r_fiw + 3'd1;
                        end
                    end else begin
                        n_eiw = r_eiw + EW'(1);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim     <= 8'd80;
            r_m       <= 3'd7;
            r_n       <= 3'd6;
            r_cmvn    <= 1'b0;
            r_eif     <= '0;
            r_frames  <= '0;
            r_wn      <= '0;
            r_fiw     <= '0;
            r_eiw     <= '0;
            r_ended   <= 1'b0;
            r_wr_slot <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (lfs_pkg::t_cfg_index'(i_cfg_index))
                    lfs_pkg::CFG_DIM:    r_dim  <= i_cfg_data;
                    lfs_pkg::CFG_FRAMES: r_m    <= i_cfg_data[2:0];
                    lfs_pkg::CFG_STRIDE: r_n    <= i_cfg_data[2:0];
                    lfs_pkg::CFG_CMVN:   r_cmvn <= i_cfg_data[0];
                    default:             r_cmvn <= r_cmvn;
                endcase
            end
            if (accept) begin
                r_eif     <= n_eif;
                r_frames  <= n_frames;
                r_wn      <= n_wn;
                r_fiw     <= n_fiw;
                r_eiw     <= n_eiw;
                r_ended   <= n_ended;
                r_wr_slot <= n_wr_slot;
            end
        end
    end

endmodule

>>> rtl/lfs_back.sv
module lfs_back #(
    parameter int MAX_DIM     = 128,
    parameter int RING_FRAMES = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lfs_pkg::t_req i_req,
    input  logic          i_q_empty,
    output logic          o_q_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [1:0]    o_status,
    output logic [15:0]   o_out_value,
    output logic          o_last_of_window,
    output logic          o_last_of_utterance
);

    localparam int RING_DEPTH = RING_FRAMES * MAX_DIM;
    localparam int RAW        = $clog2(RING_DEPTH);

    logic [15:0] r_ring  [RING_DEPTH];
    logic [15:0] r_mean  [1024];
    logic [15:0] r_scale [1024];

    logic          en;
    logic          r_v1, r_v2;
    lfs_pkg::t_req r_req1, r_req2;
    logic [15:0]   r_x1, r_mean1, r_scale1;
    logic [15:0]   r_x2;
    logic [32:0]   r_prod2;
    logic [16:0]   sum1;
    logic [33:0]   rnd;
    logic [21:0]   q;
    logic [15:0]   sat;
    logic          is_rd;

    assign en      = !o_out_valid || i_out_ready;
    assign o_q_pop = en && !i_q_empty;

    // stage 1: memory access
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            case (i_req.op)
                lfs_pkg::OP_RING_WR:  r_ring[i_req.ring_addr[RAW-1:0]] <= i_req.data;
                lfs_pkg::OP_MEAN_WR:  r_mean[i_req.coef_addr]  <= i_req.data;
                lfs_pkg::OP_SCALE_WR: r_scale[i_req.coef_addr] <= i_req.data;
                default: ;
            endcase
        end
        if (en) begin
            r_req1   <= i_req;
            r_x1     <= r_ring[i_req.ring_addr[RAW-1:0]];
            r_mean1  <= r_mean[i_req.coef_addr];
            r_scale1 <= r_scale[i_req.coef_addr];
        end
    end

    // stage 2: shift and scale, Q8.8 x Q4.12
    assign sum1 = {r_x1[15], r_x1} + {r_mean1[15], r_mean1};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_req2  <= r_req1;
            r_x2    <= r_x1;
            r_prod2 <= 33'($signed(sum1) * $signed(r_scale1));
        end
    end

    // stage 3: round half up, saturate
    assign rnd = {r_prod2[32], r_prod2} + 34'd2048;
    assign q   = rnd[33:12];
    always_comb begin
        if ($signed(q) > $signed(22'sd32767)) begin
            sat = 16'h7FFF;
        end else if ($signed(q) < -$signed(22'sd32768)) begin
            sat = 16'h8000;
        end else begin
            sat = q[15:0];
        end
    end
    assign is_rd = (r_req2.op == lfs_pkg::OP_READ);

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_status            <= r_req2.status;
            o_out_value         <= !is_rd ? 16'd0 : (r_req2.cmvn ? sat : r_x2);
            o_last_of_window    <= is_rd && r_req2.last_w;
            o_last_of_utterance <= is_rd && r_req2.last_u;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (en) begin
            r_v1        <= o_q_pop;
            r_v2        <= r_v1;
            o_out_valid <= r_v2;
        end
    end

endmodule
